FILE: hdl/stmaa_pkg.sv
package stmaa_pkg;

    // Default table size and window length.
    localparam int MAX_SENSORS_DEFAULT = 16;
    localparam int WINDOW_DEFAULT      = 5;

    // Quotient bits the divider resolves per cycle.
    localparam int DIV_BITS = 4;

    // Threshold reset values in Q7.8 degrees.
    localparam logic signed [15:0] MAX_TEMP_RESET = 16'sd5120;
    localparam logic signed [15:0] MIN_TEMP_RESET = 16'sd2560;

    // Configuration register indexes.
    localparam logic REG_MAX_TEMP = 1'b0;
    localparam logic REG_MIN_TEMP = 1'b1;

    // Item modes.
    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_SAMPLE   = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_REGISTERED = 2'd0,
        ST_FULL       = 2'd1,
        ST_TAKEN      = 2'd2,
        ST_UNKNOWN    = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_WR,
        S_SUM,
        S_DIV,
        S_OUT
    } state_t;

endpackage

FILE: hdl/sensor_table_moving_average_alarm.sv
// Register items go from acceptance straight to the output state. Unknown sensors pass through
// the id search, one table entry per cycle, before the output state.
// Sample items pass through the one-entry-per-cycle id search, the window write, the window
// read-back and a 4-bit-per-cycle divider before the output state, which stalls on a held result.
// One item is in work at a time. Synchronous active-low reset clears the count and loads the
// thresholds with their reset values.
module sensor_table_moving_average_alarm #(
    parameter int MAX_SENSORS = stmaa_pkg::MAX_SENSORS_DEFAULT,
    parameter int WINDOW      = stmaa_pkg::WINDOW_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [15:0]        s_sensor_id,
    input  logic [15:0]        s_room_id,
    input  logic signed [15:0] s_sample,
    input  logic [31:0]        s_timestamp,
    // Result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [15:0]        m_found_room,
    output logic signed [15:0] m_average,
    output logic               m_too_hot,
    output logic               m_too_cold,
    output logic [31:0]        m_last_time,
    // Configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int SLOT_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int SCNT_W   = $clog2(MAX_SENSORS + 1);
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WDEPTH   = MAX_SENSORS * WINDOW;
    localparam int WADDR_W  = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int REC_W    = 32 + CNT_W + PTR_W;
    localparam int SUM_W    = 16 + CNT_W;
    localparam int DIV_ITERS = (SUM_W + stmaa_pkg::DIV_BITS - 1) / stmaa_pkg::DIV_BITS;
    localparam int DIVW     = DIV_ITERS * stmaa_pkg::DIV_BITS;
    localparam int DCNT_W   = $clog2(DIV_ITERS + 1);

    stmaa_pkg::state_t  state_reg, state_next;
    stmaa_pkg::status_t status_reg;

    // Control registers
    logic [SCNT_W-1:0]        count_reg;
    logic [SCNT_W-1:0]        idx_reg;
    logic                     pend_reg;
    logic [CNT_W-1:0]         k_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    logic                     m_valid_reg;
    logic signed [15:0]       max_temp_reg;
    logic signed [15:0]       min_temp_reg;

    // Payload registers
    logic [15:0]              id_reg;
    logic signed [15:0]       sample_reg;
    logic [31:0]              ts_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [15:0]              room_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [PTR_W-1:0]         head_reg;
    logic [WADDR_W-1:0]       base_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     neg_reg;
    logic [DIVW-1:0]          quo_reg;
    logic [CNT_W:0]           rem_reg;
    logic [1:0]               m_status_reg;
    logic [15:0]              m_room_reg;
    logic signed [15:0]       m_avg_reg;
    logic                     m_hot_reg;
    logic                     m_cold_reg;
    logic [31:0]              m_time_reg;

    // Memory ports
    logic                     rec_we;
    logic [SLOT_W-1:0]        rec_waddr;
    logic [REC_W-1:0]         rec_wdata;
    logic [SLOT_W-1:0]        rec_raddr;
    logic [REC_W-1:0]         rec_rdata;
    logic                     win_we;
    logic [WADDR_W-1:0]       win_waddr;
    logic [WADDR_W-1:0]       win_raddr;
    logic [15:0]              win_rdata;

    // Record fields read back from the sensor table
    logic [15:0]              rd_id;
    logic [15:0]              rd_room;
    logic [CNT_W-1:0]         rd_fill;
    logic [PTR_W-1:0]         rd_head;

    logic                     in_acc;
    logic                     table_full;
    logic                     srch_match;
    logic                     srch_more;
    logic                     sum_more;
    logic                     div_last;
    logic                     out_free;
    logic [CNT_W-1:0]         fill_new;
    logic [PTR_W-1:0]         head_new;
    logic [SUM_W-1:0]         acc_mag;
    logic [DIVW-1:0]          quo_step;
    logic [CNT_W:0]           rem_step;
    logic signed [15:0]       avg_c;
    logic                     hot_c;
    logic                     taken;

    assign {rd_id, rd_room, rd_fill, rd_head} = rec_rdata;

    // Handshake and status terms.
    assign in_acc     = s_valid && s_ready;
    assign table_full = (count_reg == SCNT_W'(MAX_SENSORS));
    assign srch_match = pend_reg && (rd_id == id_reg);
    assign srch_more  = (idx_reg != count_reg);
    assign sum_more   = (k_reg != fill_reg);
    assign div_last   = (dcnt_reg == DCNT_W'(DIV_ITERS - 1));
    assign out_free   = !m_valid_reg || m_ready;
    assign cfg_ready  = 1'b1;

    // Window bookkeeping: the window is a ring, head marks the oldest sample once full.
    assign fill_new = (rd_fill == CNT_W'(WINDOW)) ? rd_fill : rd_fill + 1'b1;
    assign head_new = (rd_head == PTR_W'(WINDOW - 1)) ? '0 : rd_head + 1'b1;

    // Magnitude of the window sum for the unsigned divider.
    assign acc_mag = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);

    // Restoring divider, several quotient bits per cycle.
    always_comb begin
        logic [CNT_W:0]  r;
        logic [DIVW-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int j = 0; j < stmaa_pkg::DIV_BITS; j++) begin
            r = {r[CNT_W-1:0], q[DIVW-1]};
            q = {q[DIVW-2:0], 1'b0};
            if (r >= {1'b0, fill_reg}) begin
                r = r - {1'b0, fill_reg};
                q[0] = 1'b1;
            end
        end
        rem_step = r;
        quo_step = q;
    end

    // Signed mean, truncated toward zero, and the alarm flags.
    assign avg_c = neg_reg ? -$signed(quo_reg[15:0]) : $signed(quo_reg[15:0]);
    assign hot_c = (avg_c > max_temp_reg);
    assign taken = (status_reg == stmaa_pkg::ST_TAKEN);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stmaa_pkg::S_IDLE: begin
                if (in_acc) begin
                    state_next = (s_mode == stmaa_pkg::MODE_SAMPLE) ? stmaa_pkg::S_SRCH
                                                                    : stmaa_pkg::S_OUT;
                end
            end
            stmaa_pkg::S_SRCH: begin
                if (srch_match) begin
                    state_next = stmaa_pkg::S_WR;
                end else if (!srch_more) begin
                    state_next = stmaa_pkg::S_OUT;
                end
            end
            stmaa_pkg::S_WR: begin
                state_next = stmaa_pkg::S_SUM;
            end
            stmaa_pkg::S_SUM: begin
                if (!pend_reg && !sum_more) begin
                    state_next = stmaa_pkg::S_DIV;
                end
            end
            stmaa_pkg::S_DIV: begin
                if (div_last) begin
                    state_next = stmaa_pkg::S_OUT;
                end
            end
            stmaa_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = stmaa_pkg::S_IDLE;
                end
            end
            default: state_next = stmaa_pkg::S_IDLE;
        endcase
    end

    // Memory controls and input ready.
    always_comb begin
        s_ready   = 1'b0;
        rec_we    = 1'b0;
        rec_waddr = slot_reg;
        rec_wdata = {id_reg, room_reg, fill_new, head_new};
        rec_raddr = idx_reg[SLOT_W-1:0];
        win_we    = 1'b0;
        win_waddr = base_reg + WADDR_W'(head_reg);
        win_raddr = base_reg + WADDR_W'(k_reg);
        unique case (state_reg)
            stmaa_pkg::S_IDLE: begin
                s_ready = 1'b1;
                // A new sensor goes into the next free row with an empty window.
                if (in_acc && s_mode == stmaa_pkg::MODE_REGISTER && !table_full) begin
                    rec_we    = 1'b1;
                    rec_waddr = count_reg[SLOT_W-1:0];
                    rec_wdata = {s_sensor_id, s_room_id, CNT_W'(0), PTR_W'(0)};
                end
            end
            stmaa_pkg::S_SRCH: begin
                // Keep the matched record on the read port for the write state.
                if (srch_match) begin
                    rec_raddr = slot_reg;
                end
            end
            stmaa_pkg::S_WR: begin
                rec_we = 1'b1;
                win_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stmaa_pkg::S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            k_reg        <= '0;
            dcnt_reg     <= '0;
            m_valid_reg  <= 1'b0;
            max_temp_reg <= stmaa_pkg::MAX_TEMP_RESET;
            min_temp_reg <= stmaa_pkg::MIN_TEMP_RESET;
        end else begin
            state_reg <= state_next;

            // Threshold writes.
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    stmaa_pkg::REG_MAX_TEMP: max_temp_reg <= $signed(cfg_data);
                    stmaa_pkg::REG_MIN_TEMP: min_temp_reg <= $signed(cfg_data);
                    default: begin
                    end
                endcase
            end

            // Sensor count grows with every accepted registration while the table is not full.
            if (in_acc && s_mode == stmaa_pkg::MODE_REGISTER && !table_full) begin
                count_reg <= count_reg + 1'b1;
            end

            // Search and sum loops issue one read per cycle.
            unique case (state_reg)
                stmaa_pkg::S_IDLE: begin
                    idx_reg  <= '0;
                    pend_reg <= 1'b0;
                end
                stmaa_pkg::S_SRCH: begin
                    if (!srch_match && srch_more) begin
                        idx_reg  <= idx_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                end
                stmaa_pkg::S_WR: begin
                    k_reg    <= '0;
                    pend_reg <= 1'b0;
                end
                stmaa_pkg::S_SUM: begin
                    pend_reg <= sum_more;
                    if (sum_more) begin
                        k_reg <= k_reg + 1'b1;
                    end
                    dcnt_reg <= '0;
                end
                stmaa_pkg::S_DIV: begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                default: begin
                end
            endcase

            // Output register.
            if (state_reg == stmaa_pkg::S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            stmaa_pkg::S_IDLE: begin
                if (in_acc) begin
                    id_reg     <= s_sensor_id;
                    sample_reg <= s_sample;
                    ts_reg     <= s_timestamp;
                    if (s_mode == stmaa_pkg::MODE_SAMPLE) begin
                        status_reg <= stmaa_pkg::ST_UNKNOWN;
                    end else begin
                        status_reg <= table_full ? stmaa_pkg::ST_FULL
                                                 : stmaa_pkg::ST_REGISTERED;
                    end
                end
            end
            stmaa_pkg::S_SRCH: begin
                if (srch_match) begin
                    room_reg   <= rd_room;
                    head_reg   <= rd_head;
                    base_reg   <= WADDR_W'(slot_reg) * WADDR_W'(WINDOW);
                    status_reg <= stmaa_pkg::ST_TAKEN;
                end else if (srch_more) begin
                    slot_reg <= idx_reg[SLOT_W-1:0];
                end
            end
            stmaa_pkg::S_WR: begin
                fill_reg <= fill_new;
                acc_reg  <= '0;
            end
            stmaa_pkg::S_SUM: begin
                if (pend_reg) begin
                    acc_reg <= acc_reg + SUM_W'($signed(win_rdata));
                end else if (!sum_more) begin
                    neg_reg <= acc_reg[SUM_W-1];
                    quo_reg <= DIVW'(acc_mag);
                    rem_reg <= '0;
                end
            end
            stmaa_pkg::S_DIV: begin
                quo_reg <= quo_step;
                rem_reg <= rem_step;
            end
            stmaa_pkg::S_OUT: begin
                if (out_free) begin
                    m_status_reg <= status_reg;
                    m_room_reg   <= taken ? room_reg : '0;
                    m_avg_reg    <= taken ? avg_c : '0;
                    m_hot_reg    <= taken && hot_c;
                    m_cold_reg   <= taken && !hot_c && (avg_c < min_temp_reg);
                    m_time_reg   <= taken ? ts_reg : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // The old window entry and head are taken from the record read during the search,
    // which stays on the read port while the sequencer sits in the write state.
    // Sensor table: id, room, fill count and ring head for each sensor.
    stmaa_ram #(
        .WIDTH(REC_W),
        .DEPTH(MAX_SENSORS)
    ) u_rec_ram (
        .aclk (aclk),
        .we   (rec_we),
        .waddr(rec_waddr),
        .wdata(rec_wdata),
        .raddr(rec_raddr),
        .rdata(rec_rdata)
    );

    // Sample windows, WINDOW entries per sensor.
    stmaa_ram #(
        .WIDTH(16),
        .DEPTH(WDEPTH)
    ) u_win_ram (
        .aclk (aclk),
        .we   (win_we),
        .waddr(win_waddr),
        .wdata(sample_reg),
        .raddr(win_raddr),
        .rdata(win_rdata)
    );

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found_room = m_room_reg;
    assign m_average    = m_avg_reg;
    assign m_too_hot    = m_hot_reg;
    assign m_too_cold   = m_cold_reg;
    assign m_last_time  = m_time_reg;

endmodule

FILE: hdl/stmaa_ram.sv
module stmaa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    // One write port and one read port with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;

endmodule

FILE: hdl/stmaa_checker.sv
module stmaa_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic [15:0]        m_found_room,
    input logic signed [15:0] m_average,
    input logic               m_too_hot,
    input logic               m_too_cold,
    input logic [31:0]        m_last_time
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    // Only a taken sample carries room, mean, flags and time.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != stmaa_pkg::ST_TAKEN |->
            m_found_room == '0 && m_average == '0 && !m_too_hot && !m_too_cold
            && m_last_time == '0)
        else $error("non-sample result carries data");

    // The two alarms never fire together.
    a_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_too_hot && m_too_cold))
        else $error("too hot and too cold at once");

    // The block works on one item at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

endmodule

bind sensor_table_moving_average_alarm stmaa_checker u_stmaa_checker (.*);

FILE: test/tb_sensor_table_moving_average_alarm.sv
module tb_sensor_table_moving_average_alarm;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SENSORS = stmaa_pkg::MAX_SENSORS_DEFAULT;
    localparam int WIN_LEN     = stmaa_pkg::WINDOW_DEFAULT;
    localparam int PHASE_ITEMS = 300;
    localparam int NUM_PHASES  = 6;

    // One input item as the sender presents it.
    typedef struct {
        logic               mode;
        logic [15:0]        id;
        logic [15:0]        room;
        logic signed [15:0] smp;
        logic [31:0]        ts;
    } sensor_item_t;

    // One result item as the block should report it.
    typedef struct {
        stmaa_pkg::status_t status;
        logic [15:0]        room;
        logic signed [15:0] avg;
        logic               hot;
        logic               cold;
        logic [31:0]        ts;
    } alarm_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_mode = stmaa_pkg::MODE_REGISTER;
    logic [15:0]        s_sensor_id = '0;
    logic [15:0]        s_room_id = '0;
    logic signed [15:0] s_sample = '0;
    logic [31:0]        s_timestamp = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [15:0]        m_found_room;
    logic signed [15:0] m_average;
    logic               m_too_hot;
    logic               m_too_cold;
    logic [31:0]        m_last_time;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = stmaa_pkg::REG_MAX_TEMP;
    logic [15:0]        cfg_data = '0;

    sensor_table_moving_average_alarm DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_sensor_id  (s_sensor_id),
        .s_room_id    (s_room_id),
        .s_sample     (s_sample),
        .s_timestamp  (s_timestamp),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found_room (m_found_room),
        .m_average    (m_average),
        .m_too_hot    (m_too_hot),
        .m_too_cold   (m_too_cold),
        .m_last_time  (m_last_time),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Pending items for the sender and results still owed by the block.
    sensor_item_t  pend_q[$];
    alarm_result_t alarm_q[$];
    int            err_count = 0;

    // Idling controls, set per phase.
    bit            bursty = 1'b1;
    logic [16:0]   ready_pattern = '1;

    // Predicted copy of the sensor table and thresholds.
    logic [15:0]        tab_id[NUM_SENSORS];
    logic [15:0]        tab_room[NUM_SENSORS];
    logic signed [15:0] tab_win[NUM_SENSORS][WIN_LEN];
    int                 tab_fill[NUM_SENSORS];
    logic [31:0]        tab_time[NUM_SENSORS];
    int                 tab_count = 0;
    logic signed [15:0] thr_hot = stmaa_pkg::MAX_TEMP_RESET;
    logic signed [15:0] thr_cold = stmaa_pkg::MIN_TEMP_RESET;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Apply one item to the predicted table and work out the alarm result.
    function automatic alarm_result_t alarm_predict(sensor_item_t it);
        alarm_result_t r;
        int slot;
        int sum;
        int mean;
        bit hit;
        r.status = stmaa_pkg::ST_REGISTERED;
        r.room = '0;
        r.avg = '0;
        r.hot = 1'b0;
        r.cold = 1'b0;
        r.ts = '0;
        slot = 0;
        hit = 1'b0;
        sum = 0;
        if (it.mode == stmaa_pkg::MODE_REGISTER) begin
            if (tab_count < NUM_SENSORS) begin
                tab_id[tab_count] = it.id;
                tab_room[tab_count] = it.room;
                for (int k = 0; k < WIN_LEN; k++) tab_win[tab_count][k] = '0;
                tab_fill[tab_count] = 0;
                tab_time[tab_count] = '0;
                tab_count++;
            end else begin
                r.status = stmaa_pkg::ST_FULL;
            end
            return r;
        end
        // Only the first matching entry counts.
        for (int i = 0; i < tab_count; i++) begin
            if (!hit && tab_id[i] == it.id) begin
                slot = i;
                hit = 1'b1;
            end
        end
        if (!hit) begin
            r.status = stmaa_pkg::ST_UNKNOWN;
            return r;
        end
        // Shift the sample into the window, dropping the oldest when full.
        if (tab_fill[slot] >= WIN_LEN) begin
            for (int k = 0; k < WIN_LEN - 1; k++) tab_win[slot][k] = tab_win[slot][k + 1];
            tab_win[slot][WIN_LEN - 1] = it.smp;
        end else begin
            tab_win[slot][tab_fill[slot]] = it.smp;
            tab_fill[slot]++;
        end
        tab_time[slot] = it.ts;
        for (int k = 0; k < tab_fill[slot]; k++) sum += int'(tab_win[slot][k]);
        mean = sum / tab_fill[slot];
        r.status = stmaa_pkg::ST_TAKEN;
        r.room = tab_room[slot];
        r.avg = mean[15:0];
        r.hot = (mean > int'(thr_hot));
        r.cold = !r.hot && (mean < int'(thr_cold));
        r.ts = tab_time[slot];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // Sender: bursts of items separated by random gaps.
    int           burst_left = 1;
    int           gap_left = 0;
    sensor_item_t cur_item;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                alarm_q.push_back(alarm_predict(cur_item));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pend_q.size() > 0) begin
                    cur_item = pend_q.pop_front();
                    s_mode <= cur_item.mode;
                    s_sensor_id <= cur_item.id;
                    s_room_id <= cur_item.room;
                    s_sample <= cur_item.smp;
                    s_timestamp <= cur_item.ts;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = (bursty && $urandom_range(0, 2) != 0) ?
                                   $urandom_range(1, 12) : 0;
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls on a repeating 17-bit ready pattern and checks each result item.
    int            stall_pos = 0;
    alarm_result_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (alarm_q.size() == 0) begin
                    report_mismatch("unexpected result status", m_status, 0);
                end else begin
                    want = alarm_q.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_found_room !== want.room)
                        report_mismatch("found_room", m_found_room, want.room);
                    if (m_average !== want.avg)
                        report_mismatch("average", m_average, want.avg);
                    if (m_too_hot !== want.hot)
                        report_mismatch("too_hot", m_too_hot, want.hot);
                    if (m_too_cold !== want.cold)
                        report_mismatch("too_cold", m_too_cold, want.cold);
                    if (m_last_time !== want.ts)
                        report_mismatch("last_time", m_last_time, want.ts);
                end
            end
            m_ready <= ready_pattern[stall_pos];
            stall_pos = (stall_pos == 16) ? 0 : stall_pos + 1;
        end
    end

    task automatic push_item(logic mode, logic [15:0] id, logic [15:0] room,
                             logic signed [15:0] smp, logic [31:0] ts);
        sensor_item_t it;
        it.mode = mode;
        it.id = id;
        it.room = room;
        it.smp = smp;
        it.ts = ts;
        pend_q.push_back(it);
    endtask

    // Wait until every item is accepted and every result is back; the falling edge
    // sees the sender's queue and valid after they have settled.
    task automatic wait_drained();
        while (pend_q.size() != 0 || s_valid || alarm_q.size() != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(logic idx, logic signed [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == stmaa_pkg::REG_MAX_TEMP) thr_hot = val;
        else thr_cold = val;
        cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed items at reset thresholds, then random phases.
    initial begin
        logic [15:0]        gen_ids[$];
        int                 gen_regs;
        logic signed [15:0] hi_set;
        logic signed [15:0] lo_set;
        logic signed [15:0] smp;
        logic [15:0]        id;
        int                 pick;

        gen_regs = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Lookup into an empty table, then a few registrations with a duplicate id.
        push_item(stmaa_pkg::MODE_SAMPLE, 16'h1234, 16'hFFFF, 16'sh7FFF, 32'hFFFF_FFFF);
        push_item(stmaa_pkg::MODE_REGISTER, 16'h0000, 16'hFFFF, 16'sh7FFF, 32'hFFFF_FFFF);
        push_item(stmaa_pkg::MODE_REGISTER, 16'hFFFF, 16'h0000, 16'sh8000, 32'h0);
        push_item(stmaa_pkg::MODE_REGISTER, 16'hFFFF, 16'h5A5A, 16'sh0, 32'h0);
        push_item(stmaa_pkg::MODE_REGISTER, 16'h8001, 16'h00FF, 16'sh0, 32'h0);
        push_item(stmaa_pkg::MODE_REGISTER, 16'h0101, 16'h0007, 16'sh0, 32'h0);
        gen_ids = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h8001, 16'h0101};
        gen_regs = 5;
        // Fill one window at the positive extreme, then push the negative extreme in.
        for (int k = 0; k < WIN_LEN; k++)
            push_item(stmaa_pkg::MODE_SAMPLE, 16'h0000, 16'h0000, 16'sh7FFF,
                      32'hFFFF_FFFF - k);
        push_item(stmaa_pkg::MODE_SAMPLE, 16'h0000, 16'hFFFF, 16'sh8000, 32'h8000_0000);
        // Duplicate id resolves to the first entry; negative extreme is too cold.
        push_item(stmaa_pkg::MODE_SAMPLE, 16'hFFFF, 16'h1111, 16'sh8000, 32'h0);
        push_item(stmaa_pkg::MODE_SAMPLE, 16'hFFFF, 16'h2222, 16'sh8000, 32'h1);
        // Just above the upper threshold, then exactly on the lower one, then below.
        push_item(stmaa_pkg::MODE_SAMPLE, 16'h8001, 16'h0, 16'sd5121, 32'h10);
        push_item(stmaa_pkg::MODE_SAMPLE, 16'h8001, 16'h0, -16'sd1, 32'h20);
        push_item(stmaa_pkg::MODE_SAMPLE, 16'h8001, 16'h0, -16'sd2, 32'h30);
        // Negative sums truncate toward zero.
        push_item(stmaa_pkg::MODE_SAMPLE, 16'h0101, 16'h0, -16'sd3, 32'h40);
        push_item(stmaa_pkg::MODE_SAMPLE, 16'h0101, 16'h0, 16'sd1, 32'h50);
        push_item(stmaa_pkg::MODE_SAMPLE, 16'h0101, 16'h0, 16'sd0, 32'h60);
        push_item(stmaa_pkg::MODE_SAMPLE, 16'h7777, 16'h0, 16'sd100, 32'h70);
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin hi_set = 16'sh7FFF; lo_set = 16'sh8000; end
                1: begin hi_set = 16'sh8000; lo_set = 16'sh7FFF; end
                2: begin
                    hi_set = stmaa_pkg::MAX_TEMP_RESET;
                    lo_set = stmaa_pkg::MIN_TEMP_RESET;
                end
                3: begin hi_set = 16'sh0; lo_set = 16'sh0; end
                default: begin hi_set = 16'($urandom); lo_set = 16'($urandom); end
            endcase
            write_threshold(stmaa_pkg::REG_MAX_TEMP, hi_set);
            write_threshold(stmaa_pkg::REG_MIN_TEMP, lo_set);
            bursty = (ph % 2 == 1) || (ph == 4);
            case (ph)
                0: ready_pattern = '1;
                2: ready_pattern = 17'h00001;
                default: ready_pattern = 17'($urandom) | 17'h00101;
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 5))
                    0, 1: smp = 16'($urandom);
                    2: smp = 16'(hi_set + $urandom_range(0, 8) - 4);
                    3: smp = 16'(lo_set + $urandom_range(0, 8) - 4);
                    4: smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    default: smp = 16'($urandom_range(0, 20) - 10);
                endcase
                if (pick < 6) begin
                    // Registration: some reuse an existing id; the table eventually fills.
                    id = ($urandom_range(0, 3) == 0) ?
                         gen_ids[$urandom_range(0, gen_ids.size() - 1)] : 16'($urandom);
                    if (gen_regs < NUM_SENSORS) begin
                        gen_ids.push_back(id);
                        gen_regs++;
                    end
                    push_item(stmaa_pkg::MODE_REGISTER, id, 16'($urandom), smp, $urandom);
                end else if (pick < 12) begin
                    push_item(stmaa_pkg::MODE_SAMPLE, 16'($urandom), 16'($urandom), smp,
                              $urandom);
                end else begin
                    id = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
                    push_item(stmaa_pkg::MODE_SAMPLE, id, 16'($urandom), smp, $urandom);
                end
            end
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog in case the block hangs.
    initial begin
        #1_500_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
